// ===== hdl/rcp_pkg.sv =====
// Types and constants shared by the radar and camera presence controller.
`timescale 1ns / 1ps
package rcp_pkg;

  localparam logic [1:0] MODE_RADAR  = 2'd0;
  localparam logic [1:0] MODE_CAMERA = 2'd1;
  localparam logic [1:0] MODE_GRACE  = 2'd2;

  localparam logic [15:0] WAIT_RADAR_MS  = 16'd50;
  localparam logic [15:0] WAIT_CAMERA_MS = 16'd80;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_DELAY = 8'd3;

  localparam logic [15:0] HOLD_TIME_RST   = 16'd3000;
  localparam logic [7:0]  CONFIRM_RST     = 8'd3;
  localparam logic [7:0]  LOST_RST        = 8'd10;
  localparam logic [15:0] GRACE_DELAY_RST = 16'd1000;

  typedef struct packed {
    logic        radar_presence;
    logic        camera_start_ok;
    logic        person_seen;
    logic [15:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        radar_power;
    logic        camera_on;
    logic        motion_event;
    logic        camera_error_event;
    logic        person_visible_event;
    logic        person_back_event;
    logic [15:0] wait_ms;
  } out_t;

  typedef struct packed {
    logic [15:0] hold_time_ms;
    logic [7:0]  confirm_frames;
    logic [7:0]  lost_frames;
    logic [15:0] grace_delay_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  confirm_count;
    logic [7:0]  lost_count;
    logic [15:0] camera_time_ms;
  } state_t;

endpackage

// ===== hdl/radar_camera_presence_controller.sv =====
// Top level of the radar and camera presence controller.
`timescale 1ns / 1ps
// One poll request in gives one result out. A request is captured in an input
// register, resolved in combinational logic against the mode, counters and
// camera timer, and written to an output register. One request per clock is
// taken unless out_ready stalls the output; out_valid rises when the result is
// written to the free output register, which decouples the two sides: a new
// request is taken while an earlier result still waits. Configuration writes
// are taken at any time on their own port; indexes above 3 are ignored.
module radar_camera_presence_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rcp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rcp_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcp_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import rcp_pkg::*;

  cfg_regs_t cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  in_t       in_r;
  logic      in_valid_r;
  out_t      out_r;
  out_t      out_nxt;
  logic      out_valid_r;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rcp_step u_step (
    .cfg_i   (cfg_r),
    .state_i (state_r),
    .in_i    (in_r),
    .state_o (state_nxt),
    .out_o   (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms   <= HOLD_TIME_RST;
      cfg_r.confirm_frames <= CONFIRM_RST;
      cfg_r.lost_frames    <= LOST_RST;
      cfg_r.grace_delay_ms <= GRACE_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD_TIME:   cfg_r.hold_time_ms   <= cfg_data;
        CFG_CONFIRM:     cfg_r.confirm_frames <= cfg_data[7:0];
        CFG_LOST:        cfg_r.lost_frames    <= cfg_data[7:0];
        CFG_GRACE_DELAY: cfg_r.grace_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  a_radar_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_RADAR |-> state_r.confirm_count == 8'd0 &&
      state_r.lost_count == 8'd0 && state_r.camera_time_ms == 16'd0)
    else $error("radar mode with stale counters");

  a_err_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.camera_error_event |->
      out_r.motion_event && !out_r.camera_on && out_r.mode == MODE_RADAR)
    else $error("camera error without motion or with camera running");

  a_back_to_camera: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.person_back_event |->
      out_r.mode == MODE_CAMERA && out_r.wait_ms == WAIT_CAMERA_MS)
    else $error("person back event outside return to camera mode");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no result");

endmodule

// ===== hdl/rcp_step.sv =====
// Per-poll decision logic: next controller state and result for one request.
`timescale 1ns / 1ps
module rcp_step (
  input  rcp_pkg::cfg_regs_t cfg_i,
  input  rcp_pkg::state_t    state_i,
  input  rcp_pkg::in_t       in_i,
  output rcp_pkg::state_t    state_o,
  output rcp_pkg::out_t      out_o
);
  import rcp_pkg::*;

  logic [16:0] cam_sum;
  logic [15:0] cam_sat;
  logic [7:0]  conf_step;
  logic [7:0]  lost_step;

  always_comb begin
    cam_sum = {1'b0, state_i.camera_time_ms} + {1'b0, in_i.elapsed_ms};
    cam_sat = cam_sum[16] ? 16'hFFFF : cam_sum[15:0];
    if (in_i.person_seen) begin
      conf_step = (state_i.confirm_count == 8'hFF) ? 8'hFF : state_i.confirm_count + 8'd1;
      lost_step = 8'd0;
    end else begin
      conf_step = state_i.confirm_count;
      lost_step = (state_i.lost_count == 8'hFF) ? 8'hFF : state_i.lost_count + 8'd1;
    end
  end

  always_comb begin
    state_o = state_i;
    out_o = '0;
    out_o.wait_ms = WAIT_RADAR_MS;
    unique case (state_i.mode)
      MODE_CAMERA: begin
        state_o.camera_time_ms = cam_sat;
        state_o.lost_count = lost_step;
        state_o.confirm_count = conf_step;
        out_o.camera_on = 1'b1;
        if (conf_step >= cfg_i.confirm_frames) begin
          out_o.person_visible_event = 1'b1;
          state_o.confirm_count = cfg_i.confirm_frames;
        end
        if (!in_i.person_seen && lost_step >= cfg_i.lost_frames &&
            cam_sat >= cfg_i.hold_time_ms) begin
          state_o.mode = MODE_GRACE;
          out_o.wait_ms = cfg_i.grace_delay_ms;
        end else begin
          out_o.wait_ms = WAIT_CAMERA_MS;
        end
      end
      MODE_GRACE: begin
        if (!in_i.person_seen) begin
          state_o = '0;
          state_o.mode = MODE_RADAR;
          out_o.radar_power = 1'b1;
        end else begin
          state_o.camera_time_ms = cam_sat;
          state_o.lost_count = 8'd0;
          state_o.mode = MODE_CAMERA;
          out_o.person_back_event = 1'b1;
          out_o.camera_on = 1'b1;
          out_o.wait_ms = WAIT_CAMERA_MS;
        end
      end
      default: begin
        // radar mode; the unused code falls back to radar
        state_o.mode = MODE_RADAR;
        out_o.radar_power = 1'b1;
        if (in_i.radar_presence) begin
          out_o.motion_event = 1'b1;
          if (in_i.camera_start_ok) begin
            state_o.mode = MODE_CAMERA;
            state_o.confirm_count = 8'd0;
            state_o.lost_count = 8'd0;
            state_o.camera_time_ms = 16'd0;
            out_o.camera_on = 1'b1;
          end else begin
            out_o.camera_error_event = 1'b1;
          end
        end
      end
    endcase
    out_o.mode = state_o.mode;
  end

endmodule
